@@ hdl/sgl_pkg.sv @@
// Shared types, constants and helpers of the Shift-JIS glyph lookup unit.
`default_nettype none

package sgl_pkg;

   // Sizes
   localparam int CODE_ENTRIES_DEF = 2048;
   localparam int GLYPH_ROWS       = 8;
   localparam int ROW_W            = 3;
   localparam int GLYPH_DEPTH      = 16384;
   localparam int GLYPH_AW         = 14;
   localparam int WIDE_DEPTH       = 158;
   localparam int WIDE_AW          = 8;
   localparam int CODE_W           = 16;
   localparam int BYTE_W           = 8;
   localparam int TE_W             = 12;
   localparam int STAT_W           = 3;
   localparam int INDEX_W          = 14;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 16;
   localparam int REQ_DATA_W       = 48;
   localparam int RSP_DATA_W       = 32;

   // Register reset values
   localparam logic              CONVERT_HALF_RST  = 1'b0;
   localparam logic [TE_W-1:0]   TABLE_ENTRIES_RST = 12'd2048;
   localparam logic [CODE_W-1:0] FALLBACK_CODE_RST = 16'h81A0;

   // Byte ranges
   localparam logic [BYTE_W-1:0] LEAD1_LO   = 8'h81;
   localparam logic [BYTE_W-1:0] LEAD1_HI   = 8'h9F;
   localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hFC;
   localparam logic [BYTE_W-1:0] NARROW_LO  = 8'h20;
   localparam logic [BYTE_W-1:0] NARROW_HI  = 8'h7E;
   localparam logic [BYTE_W-1:0] KANA_LO    = 8'hA1;
   localparam logic [BYTE_W-1:0] KANA_HI    = 8'hDF;
   localparam logic [BYTE_W-1:0] KANA_BASE  = 8'd95;
   localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

   typedef enum logic [1:0] {
      FUNC_LOAD_CODE  = 2'd0,
      FUNC_LOAD_GLYPH = 2'd1,
      FUNC_LOAD_WIDE  = 2'd2,
      FUNC_TEXT       = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_FOUND    = 3'd0,
      STAT_FALLBACK = 3'd1,
      STAT_END      = 3'd2,
      STAT_CUT      = 3'd3,
      STAT_NO_GLYPH = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONVERT_HALF  = 2'd0,
      CSR_TABLE_ENTRIES = 2'd1,
      CSR_FALLBACK_CODE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WIDEN,
      ST_SEARCH,
      ST_FALLBACK,
      ST_ROWS_RD,
      ST_ROWS_OUT,
      ST_STATUS
   } unit_state_type;

   typedef enum logic [1:0] {
      SRCH_IDLE,
      SRCH_READ,
      SRCH_CMP
   } srch_state_type;

   typedef struct packed {
      logic              start;
      logic [CODE_W-1:0] code;
   } srch_req_type;

   typedef struct packed {
      logic done;
      logic found;
   } srch_rsp_type;

   function automatic logic is_lead(input logic [BYTE_W-1:0] b);
      return ((b >= LEAD1_LO) && (b <= LEAD1_HI)) || ((b >= LEAD2_LO) && (b <= LEAD2_HI));
   endfunction

endpackage

`default_nettype wire

@@ hdl/sgl_code_search.sv @@
// Code table memory with a binary search sequencer.
`default_nettype none

module sgl_code_search
   import sgl_pkg::*;
#(
   parameter int  CODE_ENTRIES = CODE_ENTRIES_DEF,
   localparam int AW    = (CODE_ENTRIES > 1) ? $clog2(CODE_ENTRIES) : 1,
   localparam int CNT_W = $clog2(CODE_ENTRIES + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [CODE_W-1:0] wr_data,
   input  wire logic [CNT_W-1:0]  entry_count,
   input  wire srch_req_type      req,
   output      srch_rsp_type      rsp,
   output      logic [AW-1:0]     index
);

   logic [CODE_W-1:0] mem [CODE_ENTRIES];
   logic [CODE_W-1:0] rd_data_ff;

   srch_state_type    state_ff, state_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [AW-1:0]     mid_ff, mid_in;
   logic [AW-1:0]     index_ff, index_in;
   logic [CODE_W-1:0] key_ff, key_in;
   logic              done_ff, done_in;
   logic              found_ff, found_in;

   logic [AW:0]       span;
   logic [AW-1:0]     mid;
   logic              key_eq;
   logic              key_gt;

   // Upper middle of the live range
   assign span   = {1'b0, hi_ff} - {1'b0, lo_ff} + (AW+1)'(1);
   assign mid    = lo_ff + span[AW:1];
   assign key_eq = (key_ff == rd_data_ff);
   assign key_gt = (key_ff > rd_data_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[mid];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SRCH_IDLE: begin
            if (req.start && (entry_count != '0)) begin
               state_in = SRCH_READ;
            end
         end
         SRCH_READ: begin
            state_in = SRCH_CMP;
         end
         SRCH_CMP: begin
            if (key_eq) begin
               state_in = SRCH_IDLE;
            end else if (key_gt) begin
               state_in = (mid_ff == hi_ff) ? SRCH_IDLE : SRCH_READ;
            end else begin
               state_in = (mid_ff == lo_ff) ? SRCH_IDLE : SRCH_READ;
            end
         end
         default: begin
            state_in = SRCH_IDLE;
         end
      endcase
   end

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      index_in = index_ff;
      key_in   = key_ff;
      done_in  = 1'b0;
      found_in = 1'b0;
      unique case (state_ff)
         SRCH_IDLE: begin
            if (req.start) begin
               key_in = req.code;
               lo_in  = '0;
               hi_in  = AW'(entry_count - CNT_W'(1));
               // empty table: nothing to probe
               if (entry_count == '0) begin
                  done_in = 1'b1;
               end
            end
         end
         SRCH_READ: begin
            mid_in = mid;
         end
         SRCH_CMP: begin
            if (key_eq) begin
               done_in  = 1'b1;
               found_in = 1'b1;
               index_in = mid_ff;
            end else if (key_gt) begin
               if (mid_ff == hi_ff) begin
                  done_in = 1'b1;
               end else begin
                  lo_in = mid_ff + AW'(1);
               end
            end else begin
               if (mid_ff == lo_ff) begin
                  done_in = 1'b1;
               end else begin
                  hi_in = mid_ff - AW'(1);
               end
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SRCH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      index_ff <= index_in;
      key_ff   <= key_in;
      found_ff <= found_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.found = found_ff;
   assign index     = index_ff;

endmodule

`default_nettype wire

@@ hdl/sjis_glyph_lookup_unit.sv @@
// Timing: a load item or a lead byte is taken in ST_IDLE alone; a NUL byte gives its status item
// through ST_STATUS once the output slot is free. A glyph character runs P probes in
// total (at most ceil(log2(entries+1)) per search, second search only for the fallback),
// then its rows, and passes ST_WIDEN first when widened. Each probe is a registered code
// table read, then a compare; each glyph row is a registered glyph store read, then an output load.
// Reset (synchronous, high) clears control state and registers; tables keep no reset.
`default_nettype none

module sjis_glyph_lookup_unit
   import sgl_pkg::*;
#(
   parameter int CODE_ENTRIES = CODE_ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // tdata from bit 0: table_index[13:0], code_word[29:14], glyph_byte[37:30],
   // text_byte[45:38], zero pad[47:46]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: func[1:0]
   input  wire logic [1:0]            req_tuser,
   // response channel
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata from bit 0: glyph_row[7:0], row_number[10:8], char_code[26:11], zero pad[31:27]
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status[2:0]
   output      logic [STAT_W-1:0]     rsp_tuser,
   output      logic                  rsp_tlast,
   // register write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = (CODE_ENTRIES > 1) ? $clog2(CODE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CODE_ENTRIES + 1);

   // ---------------------------------------------------------------- registers
   logic              convert_half_ff;
   logic [TE_W-1:0]   table_entries_ff;
   logic [CODE_W-1:0] fallback_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         convert_half_ff  <= CONVERT_HALF_RST;
         table_entries_ff <= TABLE_ENTRIES_RST;
         fallback_code_ff <= FALLBACK_CODE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONVERT_HALF:  convert_half_ff  <= csr_wdata[0];
            CSR_TABLE_ENTRIES: table_entries_ff <= csr_wdata[TE_W-1:0];
            CSR_FALLBACK_CODE: fallback_code_ff <= csr_wdata;
            default: begin
               // index past the register list: drop the write
            end
         endcase
      end
   end

   // Saturate the search size to the table depth
   logic [CNT_W-1:0] entry_count;
   always_comb begin
      if ({1'b0, table_entries_ff} > 13'(CODE_ENTRIES)) begin
         entry_count = CNT_W'(CODE_ENTRIES);
      end else begin
         entry_count = CNT_W'(table_entries_ff);
      end
   end

   // ---------------------------------------------------------------- request fields
   func_type           in_func;
   logic [INDEX_W-1:0] in_index;
   logic [CODE_W-1:0]  in_word;
   logic [BYTE_W-1:0]  in_gbyte;
   logic [BYTE_W-1:0]  in_text;

   assign in_func  = func_type'(req_tuser);
   assign in_index = req_tdata[13:0];
   assign in_word  = req_tdata[29:14];
   assign in_gbyte = req_tdata[37:30];
   assign in_text  = req_tdata[45:38];

   // ---------------------------------------------------------------- state
   unit_state_type    state_ff, state_in;
   logic              pending_ff, pending_in;
   logic [BYTE_W-1:0] lead_ff, lead_in;
   logic [CODE_W-1:0] code_ff, code_in;
   status_type        stat_ff, stat_in;
   logic [AW-1:0]     entry_ff, entry_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_row_ff, rsp_row_in;
   logic [ROW_W-1:0]  rsp_num_ff, rsp_num_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   status_type        rsp_stat_ff, rsp_stat_in;
   logic              rsp_last_ff, rsp_last_in;

   logic accept;
   logic text_item;
   logic out_free;
   logic last_row;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign text_item  = accept && (in_func == FUNC_TEXT);
   // output slot can take an item this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_row   = (row_ff == ROW_W'(GLYPH_ROWS - 1));

   // ---------------------------------------------------------------- text decode
   logic              text_nul;
   logic              text_lead;
   logic              text_narrow;
   logic              text_kana;
   logic              text_widen;
   logic [WIDE_AW-1:0] wide_rd_addr;

   assign text_nul    = (in_text == NUL_BYTE);
   assign text_lead   = is_lead(in_text);
   assign text_narrow = (in_text >= NARROW_LO) && (in_text <= NARROW_HI);
   assign text_kana   = (in_text >= KANA_LO) && (in_text <= KANA_HI);
   assign text_widen  = convert_half_ff && (text_narrow || text_kana);
   // printable ASCII maps to the first 95 entries, half-width kana after them
   assign wide_rd_addr = text_narrow ? (in_text - NARROW_LO) : (in_text - KANA_LO + KANA_BASE);

   // ---------------------------------------------------------------- memories
   logic [CODE_W-1:0]   wide_mem [WIDE_DEPTH];
   logic [CODE_W-1:0]   wide_rd_ff;
   logic [BYTE_W-1:0]   glyph_mem [GLYPH_DEPTH];
   logic [BYTE_W-1:0]   glyph_rd_ff;
   logic [GLYPH_AW-1:0] glyph_rd_addr;
   logic                wide_we;
   logic                glyph_we;
   logic                code_we;

   assign code_we  = accept && (in_func == FUNC_LOAD_CODE)
                     && ({1'b0, in_index} < 15'(CODE_ENTRIES));
   assign glyph_we = accept && (in_func == FUNC_LOAD_GLYPH);
   assign wide_we  = accept && (in_func == FUNC_LOAD_WIDE)
                     && (in_index < INDEX_W'(WIDE_DEPTH));

   // glyph byte address: entry * rows + row, wrapped to the store depth
   assign glyph_rd_addr = GLYPH_AW'({entry_ff, row_ff});

   always_ff @(posedge clock) begin
      if (wide_we) begin
         wide_mem[WIDE_AW'(in_index)] <= in_word;
      end
      wide_rd_ff <= wide_mem[wide_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem[in_index] <= in_gbyte;
      end
      glyph_rd_ff <= glyph_mem[glyph_rd_addr];
   end

   // ---------------------------------------------------------------- code search
   srch_req_type  srch_req;
   srch_rsp_type  srch_rsp;
   logic [AW-1:0] srch_index;

   sgl_code_search #(
      .CODE_ENTRIES (CODE_ENTRIES)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (code_we),
      .wr_addr     (AW'(in_index)),
      .wr_data     (in_word),
      .entry_count (entry_count),
      .req         (srch_req),
      .rsp         (srch_rsp),
      .index       (srch_index)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (text_item) begin
               if (pending_ff) begin
                  state_in = text_nul ? ST_STATUS : ST_SEARCH;
               end else if (text_nul) begin
                  state_in = ST_STATUS;
               end else if (text_lead) begin
                  state_in = ST_IDLE;
               end else if (text_widen) begin
                  state_in = ST_WIDEN;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_WIDEN: begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (srch_rsp.done) begin
               state_in = srch_rsp.found ? ST_ROWS_RD : ST_FALLBACK;
            end
         end
         ST_FALLBACK: begin
            if (srch_rsp.done) begin
               state_in = srch_rsp.found ? ST_ROWS_RD : ST_STATUS;
            end
         end
         ST_ROWS_RD: begin
            state_in = ST_ROWS_OUT;
         end
         ST_ROWS_OUT: begin
            if (out_free) begin
               state_in = last_row ? ST_IDLE : ST_ROWS_RD;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath control
   always_comb begin
      pending_in     = pending_ff;
      lead_in        = lead_ff;
      code_in        = code_ff;
      stat_in        = stat_ff;
      entry_in       = entry_ff;
      row_in         = row_ff;
      srch_req.start = 1'b0;
      srch_req.code  = code_ff;
      // drop the output item once taken, hold it otherwise
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_row_in     = rsp_row_ff;
      rsp_num_in     = rsp_num_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_stat_in    = rsp_stat_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (text_item) begin
               if (pending_ff) begin
                  pending_in = 1'b0;
                  if (text_nul) begin
                     // text ended after a lead byte
                     code_in = {lead_ff, NUL_BYTE};
                     stat_in = STAT_CUT;
                  end else begin
                     code_in        = {lead_ff, in_text};
                     srch_req.start = 1'b1;
                     srch_req.code  = {lead_ff, in_text};
                  end
               end else if (text_nul) begin
                  code_in = '0;
                  stat_in = STAT_END;
               end else if (text_lead) begin
                  lead_in    = in_text;
                  pending_in = 1'b1;
               end else begin
                  code_in = {NUL_BYTE, in_text};
                  if (!text_widen) begin
                     srch_req.start = 1'b1;
                     srch_req.code  = {NUL_BYTE, in_text};
                  end
               end
            end
         end
         ST_WIDEN: begin
            code_in        = wide_rd_ff;
            srch_req.start = 1'b1;
            srch_req.code  = wide_rd_ff;
         end
         ST_SEARCH: begin
            if (srch_rsp.done) begin
               if (srch_rsp.found) begin
                  entry_in = srch_index;
                  stat_in  = STAT_FOUND;
                  row_in   = '0;
               end else begin
                  // absent: look up the fallback code instead
                  stat_in        = STAT_FALLBACK;
                  srch_req.start = 1'b1;
                  srch_req.code  = fallback_code_ff;
               end
            end
         end
         ST_FALLBACK: begin
            if (srch_rsp.done) begin
               if (srch_rsp.found) begin
                  entry_in = srch_index;
                  row_in   = '0;
               end else begin
                  stat_in = STAT_NO_GLYPH;
               end
            end
         end
         ST_ROWS_RD: begin
            row_in = row_ff;
         end
         ST_ROWS_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = glyph_rd_ff;
               rsp_num_in   = row_ff;
               rsp_code_in  = code_ff;
               rsp_stat_in  = stat_ff;
               rsp_last_in  = last_row;
               row_in       = row_ff + ROW_W'(1);
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = '0;
               rsp_num_in   = '0;
               rsp_code_in  = code_ff;
               rsp_stat_in  = stat_ff;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b0;
         lead_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         lead_ff      <= lead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff     <= code_in;
      stat_ff     <= stat_in;
      entry_ff    <= entry_in;
      row_ff      <= row_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_code_ff <= rsp_code_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_code_ff, rsp_num_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ hdl/sgl_checker.sv @@
// Port-level checks of the glyph lookup unit and their binding.
`default_nettype none

module sgl_checker
   import sgl_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic [1:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [STAT_W-1:0]     rsp_tuser,
   input wire logic                  rsp_tlast,
   input wire logic                  csr_we,
   input wire logic [CSR_IDX_W-1:0]  csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic status_item;
   logic glyph_item;

   assign status_item = (rsp_tuser == STAT_END) || (rsp_tuser == STAT_CUT)
                        || (rsp_tuser == STAT_NO_GLYPH);
   assign glyph_item  = (rsp_tuser == STAT_FOUND) || (rsp_tuser == STAT_FALLBACK);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // status items stand alone
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_item |-> rsp_tlast && (rsp_tdata[10:0] == 11'd0))
      else $error("status item not single or not blank");

   // glyph rows close on the final row only
   a_row_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && glyph_item |-> (rsp_tlast == (rsp_tdata[10:8] == 3'd7)))
      else $error("glyph row tlast mismatch");

   // rows of one glyph come in order with the same code
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && glyph_item && !rsp_tlast ##1 rsp_tvalid
      |-> (rsp_tdata[10:8] == $past(rsp_tdata[10:8]) + 3'd1)
          && (rsp_tdata[26:11] == $past(rsp_tdata[26:11])))
      else $error("glyph rows out of order");

endmodule

bind sjis_glyph_lookup_unit sgl_checker u_sgl_checker (.*);

`default_nettype wire
